// ===== rtl/core/eabv_pkg.sv =====
`default_nettype none
package eabv_pkg;

    localparam int OutFracBits   = 14;
    localparam int AngleFracBits = 6;
    localparam int FieldW        = 16;
    localparam int AngleFracMax  = 16;

    // q2.30 working format
    localparam int QW = 32;
    localparam logic [30:0] Q30One = 31'h4000_0000;
    localparam logic [24:0] RadPerDegQ30 = 25'd18740330;

endpackage
`default_nettype wire

// ===== rtl/core/euler_angles_to_basis_vectors_core.sv =====
`default_nettype none
// channel | signals                                   | dir
// in      | in_valid/in_ready, pitch/yaw/roll_angle   | to block
// out     | out_valid/out_ready, forward/right/up_xyz | from block
// 23 register stages: reduce, quadrant, radians, square, 7 series steps of
// two stages each, sine/map, two product stages, sum, rounding.
// one beat per cycle while the output is not stalled.
// reset clears the valid bits only.
// a stall freezes the whole pipe while the output holds a beat.
module euler_angles_to_basis_vectors_core #(
    parameter int OUTPUT_FRACTION_BITS = eabv_pkg::OutFracBits,
    parameter int ANGLE_FRACTION_BITS  = eabv_pkg::AngleFracBits
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] pitch_angle,
    input  wire logic signed [15:0] yaw_angle,
    input  wire logic signed [15:0] roll_angle,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      forward_x,
    output logic signed [15:0]      forward_y,
    output logic signed [15:0]      forward_z,
    output logic signed [15:0]      right_x,
    output logic signed [15:0]      right_y,
    output logic signed [15:0]      right_z,
    output logic signed [15:0]      up_x,
    output logic signed [15:0]      up_y,
    output logic signed [15:0]      up_z
);
    import eabv_pkg::*;

    localparam int Depth = 23;
    localparam int Sh = 30 - OUTPUT_FRACTION_BITS;
    localparam longint LimRaw = 64'd1 << OUTPUT_FRACTION_BITS;
    localparam longint Lim = (LimRaw > 32767) ? 32767 : LimRaw;

    logic en;
    logic [Depth-1:0] v_reg;
    assign en = !v_reg[Depth-1] || out_ready;
    assign in_ready = en;
    assign out_valid = v_reg[Depth-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[Depth-2:0], in_valid};
        end
    end

    logic signed [31:0] sp, cp, sy, cy, sr, cr;
    eabv_trig #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_p
        (.clk, .en, .angle(pitch_angle), .sin_q(sp), .cos_q(cp));
    eabv_trig #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_y
        (.clk, .en, .angle(yaw_angle), .sin_q(sy), .cos_q(cy));
    eabv_trig #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_r
        (.clk, .en, .angle(roll_angle), .sin_q(sr), .cos_q(cr));

    // q2.30 product, rounded half away from zero
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [63:0] p;
        logic [31:0] m;
        begin
            ua = a[31] ? 32'(-a) : 32'(a);
            ub = b[31] ? 32'(-b) : 32'(b);
            p = 64'(ua) * 64'(ub);
            m = 32'((p + 64'(1 << 29)) >> 30);
            qmul = (a[31] != b[31]) ? -$signed(m) : $signed(m);
        end
    endfunction

    // product stage 1: pairs
    logic signed [31:0] srsp_reg, crsp_reg, cpcy_reg, cpsy_reg, crsy_reg, crcy_reg;
    logic signed [31:0] srcp_reg, srsy_reg, srcy_reg, crcp_reg, nsp_reg, sy1_reg, cy1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srsp_reg <= qmul(sr, sp);
            crsp_reg <= qmul(cr, sp);
            cpcy_reg <= qmul(cp, cy);
            cpsy_reg <= qmul(cp, sy);
            crsy_reg <= qmul(cr, sy);
            crcy_reg <= qmul(cr, cy);
            srcp_reg <= qmul(sr, cp);
            srsy_reg <= qmul(sr, sy);
            srcy_reg <= qmul(sr, cy);
            crcp_reg <= qmul(cr, cp);
            nsp_reg  <= -sp;
            sy1_reg  <= sy;
            cy1_reg  <= cy;
        end
    end

    // product stage 2: triples
    logic signed [31:0] a_reg [9];
    logic signed [31:0] b_reg [9];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0] <= cpcy_reg;               b_reg[0] <= '0;
            a_reg[1] <= cpsy_reg;               b_reg[1] <= '0;
            a_reg[2] <= nsp_reg;                b_reg[2] <= '0;
            a_reg[3] <= -qmul(srsp_reg, cy1_reg); b_reg[3] <= crsy_reg;
            a_reg[4] <= -qmul(srsp_reg, sy1_reg); b_reg[4] <= -crcy_reg;
            a_reg[5] <= -srcp_reg;              b_reg[5] <= '0;
            a_reg[6] <= qmul(crsp_reg, cy1_reg); b_reg[6] <= srsy_reg;
            a_reg[7] <= qmul(crsp_reg, sy1_reg); b_reg[7] <= -srcy_reg;
            a_reg[8] <= crcp_reg;               b_reg[8] <= '0;
        end
    end

    // sum, then round and saturate
    logic signed [32:0] sum_reg [9];
    logic [15:0] o_reg [9];
    for (genvar i = 0; i < 9; i++)
    begin : g_out
        logic [32:0] m;
        logic [32:0] r;
        logic [15:0] o;
        always_comb
        begin
            m = sum_reg[i][32] ? 33'(-sum_reg[i]) : 33'(sum_reg[i]);
            if (Sh > 0)
            begin
                r = (m + (33'd1 << (Sh - 1))) >> Sh;
            end
            else
            begin
                r = m;
            end
            if (r > 33'(Lim))
            begin
                r = 33'(Lim);
            end
            o = sum_reg[i][32] ? 16'(-r) : 16'(r);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sum_reg[i] <= 33'(a_reg[i]) + 33'(b_reg[i]);
                o_reg[i]   <= o;
            end
        end
    end

    assign forward_x = o_reg[0];
    assign forward_y = o_reg[1];
    assign forward_z = o_reg[2];
    assign right_x   = o_reg[3];
    assign right_y   = o_reg[4];
    assign right_z   = o_reg[5];
    assign up_x      = o_reg[6];
    assign up_y      = o_reg[7];
    assign up_z      = o_reg[8];
endmodule
`default_nettype wire

// ===== rtl/core/eabv_trig.sv =====
`default_nettype none
// sine and cosine of one angle, pipelined: reduce, quadrant, radians, square, series steps, map
module eabv_trig #(
    parameter int ANGLE_FRACTION_BITS = eabv_pkg::AngleFracBits
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [15:0]   angle,
    output logic signed [31:0]        sin_q,
    output logic signed [31:0]        cos_q
);
    import eabv_pkg::*;

    localparam int FullTurn = 360 << ANGLE_FRACTION_BITS;
    localparam int Quarter  = 90 << ANGLE_FRACTION_BITS;
    // offset that keeps the biased angle congruent to the angle modulo a turn
    localparam int TurnBias = (FullTurn - (32768 % FullTurn)) % FullTurn;
    localparam int QuarterL = $clog2(Quarter);
    localparam longint QuarterM = ((longint'(1) << (32 + QuarterL)) + Quarter - 1) / Quarter;
    // stages: reduce, quadrant, radians, square, 7 series steps of two stages, map
    localparam int NSteps = 7;

    // exact floor of n / d for any 32-bit n, m = ceil(2^(32+clog2(d)) / d)
    function automatic logic [31:0] div_const(input logic [31:0] n, input longint m,
                                              input int sh);
        logic [64:0] p;
        begin
            p = 65'(n) * 65'(m);
            div_const = 32'(p >> sh);
        end
    endfunction

    function automatic logic [30:0] series_sub(input logic [31:0] sub);
        begin
            series_sub = (sub > 32'(Q30One)) ? 31'd0 : 31'(32'(Q30One) - sub);
        end
    endfunction

    // stage 1: bias to unsigned, count quarter turns
    logic [31:0] v_c;
    logic [31:0] v0_reg;
    logic [31:0] n0_reg;
    always_comb
    begin
        v_c = 32'({~angle[15], angle[14:0]}) + 32'(TurnBias);
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v0_reg <= v_c;
            n0_reg <= div_const(v_c, QuarterM, 32 + QuarterL);
        end
    end

    // stage 2: quadrant and remainder within it
    logic [1:0]  q1_reg;
    logic [23:0] f1_reg;
    logic [31:0] f_c;
    always_comb
    begin
        f_c = v0_reg - n0_reg * 32'(Quarter);
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg <= n0_reg[1:0];
            f1_reg <= f_c[23:0];
        end
    end

    // stage 3: radians
    logic [1:0]  q2_reg;
    logic [30:0] x2_reg;
    logic [48:0] xprod;
    always_comb
    begin
        xprod = 49'(f1_reg) * 49'(RadPerDegQ30);
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q2_reg <= q1_reg;
            x2_reg <= 31'(xprod >> ANGLE_FRACTION_BITS);
        end
    end

    // stage 4: square
    logic [1:0]  q3_reg;
    logic [30:0] x3_reg;
    logic [31:0] xx3_reg;
    logic [61:0] sq;
    always_comb
    begin
        sq = 62'(x2_reg) * 62'(x2_reg);
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q3_reg  <= q2_reg;
            x3_reg  <= x2_reg;
            xx3_reg <= 32'(sq >> 30);
        end
    end

    // series: step i runs cosine k=7-i and sine k=6-i, products first,
    // then the divide by a constant and the subtract
    logic [1:0]  qa_reg  [NSteps];
    logic [30:0] xa_reg  [NSteps];
    logic [31:0] xxa_reg [NSteps];
    logic [30:0] tsa_reg [NSteps];
    logic [31:0] pc_reg  [NSteps];
    logic [31:0] ps_reg  [NSteps];
    logic [1:0]  qs_reg  [NSteps];
    logic [30:0] xs_reg  [NSteps];
    logic [31:0] xxs_reg [NSteps];
    logic [30:0] ts_reg  [NSteps];
    logic [30:0] tc_reg  [NSteps];
    logic [30:0] ts_next [NSteps];
    logic [30:0] tc_next [NSteps];

    for (genvar i = 0; i < NSteps; i++)
    begin : g_step
        logic [31:0] xx_in;
        logic [30:0] ts_in;
        logic [30:0] tc_in;
        logic [1:0]  q_in;
        logic [30:0] x_in;
        logic [61:0] pc;
        logic [61:0] ps;
        logic [31:0] sub_c;
        logic [31:0] sub_s;
        if (i == 0)
        begin : g_first
            assign xx_in = xx3_reg;
            assign ts_in = Q30One;
            assign tc_in = Q30One;
            assign q_in  = q3_reg;
            assign x_in  = x3_reg;
        end
        else
        begin : g_rest
            assign xx_in = xxs_reg[i-1];
            assign ts_in = ts_reg[i-1];
            assign tc_in = tc_reg[i-1];
            assign q_in  = qs_reg[i-1];
            assign x_in  = xs_reg[i-1];
        end
        localparam int Kc = NSteps - i;
        localparam int Ks = NSteps - 1 - i;
        localparam int Dc = (2*Kc-1)*(2*Kc);
        localparam int Ds = (Ks >= 1) ? (2*Ks)*(2*Ks+1) : 1;
        localparam int Lc = $clog2(Dc);
        localparam int Ls = $clog2(Ds);
        localparam longint Mc = ((longint'(1) << (32 + Lc)) + Dc - 1) / Dc;
        localparam longint Ms = ((longint'(1) << (32 + Ls)) + Ds - 1) / Ds;
        always_comb
        begin
            pc = 62'(xx_in) * 62'(tc_in);
            ps = 62'(xx_in) * 62'(ts_in);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qa_reg[i]  <= q_in;
                xa_reg[i]  <= x_in;
                xxa_reg[i] <= xx_in;
                tsa_reg[i] <= ts_in;
                pc_reg[i]  <= 32'(pc >> 30);
                ps_reg[i]  <= 32'(ps >> 30);
            end
        end
        always_comb
        begin
            sub_c = div_const(pc_reg[i], Mc, 32 + Lc);
            sub_s = div_const(ps_reg[i], Ms, 32 + Ls);
            tc_next[i] = series_sub(sub_c);
            ts_next[i] = (Ks >= 1) ? series_sub(sub_s) : tsa_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                qs_reg[i]  <= qa_reg[i];
                xs_reg[i]  <= xa_reg[i];
                xxs_reg[i] <= xxa_reg[i];
                ts_reg[i]  <= ts_next[i];
                tc_reg[i]  <= tc_next[i];
            end
        end
    end

    // sine product and quadrant map
    logic [61:0] sp;
    logic [30:0] s_c;
    logic signed [31:0] sv;
    logic signed [31:0] cv;
    always_comb
    begin
        sp = 62'(xs_reg[NSteps-1]) * 62'(ts_reg[NSteps-1]);
        s_c = ((sp >> 30) > 62'(Q30One)) ? Q30One : 31'(sp >> 30);
        sv = 32'(s_c);
        cv = 32'(tc_reg[NSteps-1]);
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (qs_reg[NSteps-1])
                2'd0:
                begin
                    sin_q <= sv;
                    cos_q <= cv;
                end
                2'd1:
                begin
                    sin_q <= cv;
                    cos_q <= -sv;
                end
                2'd2:
                begin
                    sin_q <= -sv;
                    cos_q <= -cv;
                end
                default:
                begin
                    sin_q <= -cv;
                    cos_q <= sv;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/eabv_checker.sv =====
`default_nettype none
module eabv_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] forward_z,
    input wire logic [15:0] up_z
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(forward_z))
        else $error("output beat dropped");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("stall without full output");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during stall");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(up_z) <= 16384 && $signed(up_z) >= -16384))
        else $error("up_z out of range");
endmodule

bind euler_angles_to_basis_vectors_core eabv_checker u_chk (
    .clk, .rst_n, .in_ready, .out_valid, .out_ready, .forward_z, .up_z);
`default_nettype wire

// ===== test/tb_euler_angles_to_basis_vectors_core.sv =====
`timescale 1ns / 1ps
module tb_euler_angles_to_basis_vectors_core;
    import eabv_pkg::*;

    localparam int LatencyCycles = 23;
    localparam longint CycleLimit = 400000;
    localparam int NumRandom = 1130;

    typedef struct packed {
        logic signed [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
    } basis_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] pitch_angle = '0;
    logic signed [15:0] yaw_angle = '0;
    logic signed [15:0] roll_angle = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] forward_x, forward_y, forward_z;
    logic signed [15:0] right_x, right_y, right_z;
    logic signed [15:0] up_x, up_y, up_z;

    basis_t expected_basis[$];
    int error_count = 0;
    longint cycle_count = 0;
    bit hold_off = 1'b0;
    bit timed_out = 1'b0;

    euler_angles_to_basis_vectors_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .pitch_angle(pitch_angle), .yaw_angle(yaw_angle), .roll_angle(roll_angle),
        .out_valid(out_valid), .out_ready(out_ready),
        .forward_x(forward_x), .forward_y(forward_y), .forward_z(forward_z),
        .right_x(right_x), .right_y(right_y), .right_z(right_z),
        .up_x(up_x), .up_y(up_y), .up_z(up_z)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit && !timed_out)
        begin
            timed_out = 1'b1;
            $display("simulation failed");
            $finish;
        end
    end

    function automatic longint horner_step(longint x2, longint t, longint d);
        longint sub;
        sub = ((x2 * t) >>> 30) / d;
        return (sub > (longint'(1) << 30)) ? 0 : (longint'(1) << 30) - sub;
    endfunction

    task automatic angle_sin_cos(input logic signed [15:0] ang,
                                 output longint sn, output longint cs);
        longint full, quarter, r, q, f, x, x2, t, s;
        full = longint'(360) << AngleFracBits;
        quarter = longint'(90) << AngleFracBits;
        r = longint'(ang) % full;
        if (r < 0)
            r += full;
        q = r / quarter;
        f = r % quarter;
        x = (f * longint'(RadPerDegQ30)) >>> AngleFracBits;
        x2 = (x * x) >>> 30;
        t = longint'(1) << 30;
        for (int k = 6; k >= 1; k--)
            t = horner_step(x2, t, (2 * k) * (2 * k + 1));
        s = (x * t) >>> 30;
        if (s > (longint'(1) << 30))
            s = longint'(1) << 30;
        t = longint'(1) << 30;
        for (int k = 7; k >= 1; k--)
            t = horner_step(x2, t, (2 * k - 1) * (2 * k));
        case (q)
            0: begin sn = s; cs = t; end
            1: begin sn = t; cs = -s; end
            2: begin sn = -s; cs = -t; end
            default: begin sn = -t; cs = s; end
        endcase
    endtask

    // rounded q2.30 product, half away from zero
    function automatic longint q30_mul(longint a, longint b);
        longint ua, ub, p;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p = (ua * ub + (longint'(1) << 29)) >>> 30;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function automatic logic signed [15:0] to_q14(longint v);
        longint m, lim;
        int sh;
        sh = 30 - OutFracBits;
        m = v < 0 ? -v : v;
        if (sh > 0)
            m = (m + (longint'(1) << (sh - 1))) >>> sh;
        lim = longint'(1) << OutFracBits;
        if (lim > 32767)
            lim = 32767;
        if (m > lim)
            m = lim;
        return v < 0 ? 16'(-m) : 16'(m);
    endfunction

    task automatic predict_basis(input logic signed [15:0] p, y, r, output basis_t b);
        longint sp, cp, sy, cy, sr, cr, srsp, crsp;
        angle_sin_cos(p, sp, cp);
        angle_sin_cos(y, sy, cy);
        angle_sin_cos(r, sr, cr);
        srsp = q30_mul(sr, sp);
        crsp = q30_mul(cr, sp);
        b.fx = to_q14(q30_mul(cp, cy));
        b.fy = to_q14(q30_mul(cp, sy));
        b.fz = to_q14(-sp);
        b.rx = to_q14(-q30_mul(srsp, cy) + q30_mul(cr, sy));
        b.ry = to_q14(-q30_mul(srsp, sy) - q30_mul(cr, cy));
        b.rz = to_q14(-q30_mul(sr, cp));
        b.ux = to_q14(q30_mul(crsp, cy) + q30_mul(sr, sy));
        b.uy = to_q14(q30_mul(crsp, sy) - q30_mul(sr, cy));
        b.uz = to_q14(q30_mul(cr, cp));
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // sends one beat; valid stays high between back-to-back beats
    task automatic send_angles(input logic signed [15:0] p, y, r, input bit idle_after);
        basis_t b;
        predict_basis(p, y, r, b);
        in_valid <= 1'b1;
        pitch_angle <= p;
        yaw_angle <= y;
        roll_angle <= r;
        do
            @(posedge clk);
        while (!in_ready);
        expected_basis.push_back(b);
        if (idle_after)
            in_valid <= 1'b0;
    endtask

    task automatic send_burst_gap();
        int gap;
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (expected_basis.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 5))
            0: return 16'($urandom());
            1: return 16'($signed($urandom_range(0, 46080)) - 23040);
            2: return 16'($urandom_range(0, 3) * 5760 + $urandom_range(0, 2) - 1);
            default: return 16'($signed($urandom_range(0, 46080)) - 23040);
        endcase
    endfunction

    // receiver: random stall pattern, optional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 9) < 7);
    end

    always @(posedge clk)
    begin
        basis_t b;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_basis.size() == 0)
            begin
                report_mismatch("unexpected beat", 1, 0);
            end
            else
            begin
                b = expected_basis.pop_front();
                if (forward_x !== b.fx) report_mismatch("forward_x", forward_x, b.fx);
                if (forward_y !== b.fy) report_mismatch("forward_y", forward_y, b.fy);
                if (forward_z !== b.fz) report_mismatch("forward_z", forward_z, b.fz);
                if (right_x !== b.rx) report_mismatch("right_x", right_x, b.rx);
                if (right_y !== b.ry) report_mismatch("right_y", right_y, b.ry);
                if (right_z !== b.rz) report_mismatch("right_z", right_z, b.rz);
                if (up_x !== b.ux) report_mismatch("up_x", up_x, b.ux);
                if (up_y !== b.uy) report_mismatch("up_y", up_y, b.uy);
                if (up_z !== b.uz) report_mismatch("up_z", up_z, b.uz);
            end
        end
    end

    task automatic test_directed();
        logic signed [15:0] corner[12];
        corner = '{16'sd0, 16'sd5760, 16'sd11520, 16'sd17280, 16'sd23040, -16'sd23040,
                   -16'sd5760, 16'sd1, -16'sd1, 16'sh7fff, -16'sh8000, 16'sd2880};
        for (int i = 0; i < 12; i++)
            send_angles(corner[i], corner[(i + 3) % 12], corner[(i + 7) % 12], 1'b0);
        send_angles(16'sd5759, 16'sd5761, 16'sd11519, 1'b0);
        send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
        send_angles(-16'sh8000, -16'sh8000, -16'sh8000, 1'b0);
        send_angles(16'sd5760, 16'sd0, 16'sd5760, 1'b1);
        wait_drained();
    endtask

    task automatic test_random();
        for (int i = 0; i < NumRandom; i++)
        begin
            send_angles(rand_angle(), rand_angle(), rand_angle(), 1'b0);
            send_burst_gap();
        end
        in_valid <= 1'b0;
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (80) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 40; i++)
                send_angles(rand_angle(), rand_angle(), rand_angle(), 1'b0);
        join
        in_valid <= 1'b0;
        wait_drained();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (LatencyCycles + 5) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ===== euler_angles_to_basis_vectors_core.f =====
rtl/core/eabv_pkg.sv
rtl/core/eabv_trig.sv
rtl/core/euler_angles_to_basis_vectors_core.sv
rtl/core/eabv_checker.sv
test/tb_euler_angles_to_basis_vectors_core.sv
